// ===== src/virtual_stick_radial_dead_zone_assert.svh =====
// Assertion macros shared by the virtual stick RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef VIRTUAL_STICK_RADIAL_DEAD_ZONE_ASSERT_SVH
`define VIRTUAL_STICK_RADIAL_DEAD_ZONE_ASSERT_SVH
`ifndef SYNTHESIS
`define VSRDZ_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("virtual stick check failed");
`define VSRDZ_CHECK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("virtual stick sequence check failed");
`else
`define VSRDZ_CHECK(lbl, cond)
`define VSRDZ_CHECK_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/vsrdz_pkg.sv =====
// Shared widths, payload types and arithmetic step functions of the virtual stick.
// No dependencies.
package vsrdz_pkg;

    localparam int IN_W      = 18;
    localparam int R_W       = 16;
    localparam int DZ_W      = 16;
    localparam int AXIS_W    = 16;
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQREM_W   = ROOT_W + 2;
    localparam int NUM_W     = 54;
    localparam int DEN_W     = 33;
    localparam int Q_W       = 22;
    localparam int QREM_W    = DEN_W + 1;
    localparam int DIV_LANES = 3;
    localparam int U_W       = 21;

    localparam logic [R_W-1:0] MIN_RADIUS = 16'd66;
    localparam logic [U_W-1:0] ONE_Q20    = 21'h100000;
    localparam logic [DZ_W-1:0] DZ_RESET  = 16'd9830;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_G = 2;

    typedef struct packed {
        logic [IN_W-1:0]   adx;
        logic [IN_W-1:0]   ady;
        logic              negx;
        logic              negy;
        logic              hi;
        logic              clamped;
        logic              kill;
        logic [31:0]       dzr;
        logic [DEN_W-1:0]  den;
    } side_t;

    typedef struct packed {
        logic negx;
        logic negy;
        logic clamped;
        logic kill;
    } tail_t;

    typedef struct packed {
        logic [SQREM_W-1:0] rem;
        logic [ROOT_W-1:0]  root;
    } sq_step_t;

    typedef struct packed {
        logic [QREM_W-1:0] rem;
        logic              qbit;
    } dv_step_t;

    // One digit of the bitwise integer square root.
    function automatic sq_step_t sqrt_step(input logic [SQREM_W-1:0] rem,
                                           input logic [ROOT_W-1:0] root,
                                           input logic [1:0] pair);
        sq_step_t           res;
        logic [SQREM_W-1:0] cur;
        logic [SQREM_W-1:0] trial;
        cur   = {rem[SQREM_W-3:0], pair};
        trial = {root, 2'b01};
        if (cur >= trial)
        begin
            res.rem  = cur - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = cur;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // One quotient bit of restoring division.
    function automatic dv_step_t div_step(input logic [QREM_W-1:0] rem,
                                          input logic nbit,
                                          input logic [DEN_W-1:0] d);
        dv_step_t          res;
        logic [QREM_W-1:0] cur;
        cur = {rem[QREM_W-2:0], nbit};
        if (cur >= {1'b0, d})
        begin
            res.rem  = cur - {1'b0, d};
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = cur;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== src/vsrdz_front.sv =====
// Front end: offsets, squares, radius products, clamp and dead-zone tests.
// Depends on vsrdz_pkg; four register stages.
module vsrdz_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [vsrdz_pkg::IN_W-1:0]      touch_x,
    input  logic [vsrdz_pkg::IN_W-1:0]      touch_y,
    input  logic [vsrdz_pkg::IN_W-1:0]      origin_x,
    input  logic [vsrdz_pkg::IN_W-1:0]      origin_y,
    input  logic [vsrdz_pkg::R_W-1:0]       stick_radius,
    input  logic [vsrdz_pkg::DZ_W-1:0]      dead_zone,
    output logic                            out_valid,
    output logic [vsrdz_pkg::RAD_W-1:0]     radicand,
    output vsrdz_pkg::side_t                side
);
    import vsrdz_pkg::*;

    logic signed [IN_W:0] dx;
    logic signed [IN_W:0] dy;
    logic [IN_W:0]        ndx;
    logic [IN_W:0]        ndy;

    logic                 a_valid_reg;
    logic [IN_W-1:0]      a_adx_reg, a_ady_reg;
    logic                 a_negx_reg, a_negy_reg;
    logic [R_W-1:0]       a_r_reg;

    logic                 b_valid_reg;
    logic [2*IN_W-1:0]    b_sqx_reg, b_sqy_reg;
    logic [31:0]          b_rr_reg, b_dzr_reg;
    logic [DEN_W-1:0]     b_den_reg;
    logic [IN_W-1:0]      b_adx_reg, b_ady_reg;
    logic                 b_negx_reg, b_negy_reg;

    logic                 c_valid_reg;
    logic [2*IN_W:0]      c_s_reg;
    logic [63:0]          c_dzr2_reg;
    logic                 c_clamped_reg;
    logic [31:0]          c_dzr_reg;
    logic [DEN_W-1:0]     c_den_reg;
    logic [IN_W-1:0]      c_adx_reg, c_ady_reg;
    logic                 c_negx_reg, c_negy_reg;

    logic                 d_valid_reg;
    logic [RAD_W-1:0]     d_v_reg;
    side_t                d_side_reg;

    logic                 hi;
    logic                 dead;
    logic [2*IN_W:0]      s_next;

    assign dx  = $signed({1'b0, touch_x}) - $signed({1'b0, origin_x});
    assign dy  = $signed({1'b0, touch_y}) - $signed({1'b0, origin_y});
    assign ndx = -dx;
    assign ndy = -dy;

    assign s_next = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    assign hi     = c_s_reg[2*IN_W:32] != '0;
    // The dead test only matters below the unit circle, where S stays under 2^32.
    assign dead   = !hi && ({c_s_reg[31:0], 32'b0} <= c_dzr2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_adx_reg  <= dx[IN_W] ? ndx[IN_W-1:0] : dx[IN_W-1:0];
            a_ady_reg  <= dy[IN_W] ? ndy[IN_W-1:0] : dy[IN_W-1:0];
            a_negx_reg <= dx[IN_W];
            a_negy_reg <= !dy[IN_W] && (dy != '0);
            a_r_reg    <= (stick_radius < MIN_RADIUS) ? MIN_RADIUS : stick_radius;

            b_sqx_reg  <= a_adx_reg * a_adx_reg;
            b_sqy_reg  <= a_ady_reg * a_ady_reg;
            b_rr_reg   <= a_r_reg * a_r_reg;
            b_dzr_reg  <= dead_zone * a_r_reg;
            b_den_reg  <= {17'b0, a_r_reg} * ({1'b0, 16'hFFFF - dead_zone} + 33'd1);
            b_adx_reg  <= a_adx_reg;
            b_ady_reg  <= a_ady_reg;
            b_negx_reg <= a_negx_reg;
            b_negy_reg <= a_negy_reg;

            c_s_reg       <= s_next;
            c_dzr2_reg    <= b_dzr_reg * b_dzr_reg;
            c_clamped_reg <= s_next > {5'b0, b_rr_reg};
            c_dzr_reg     <= b_dzr_reg;
            c_den_reg     <= b_den_reg;
            c_adx_reg     <= b_adx_reg;
            c_ady_reg     <= b_ady_reg;
            c_negx_reg    <= b_negx_reg;
            c_negy_reg    <= b_negy_reg;

            d_v_reg            <= hi ? {3'b0, c_s_reg, 24'b0} : {c_s_reg[31:0], 32'b0};
            d_side_reg.adx     <= c_adx_reg;
            d_side_reg.ady     <= c_ady_reg;
            d_side_reg.negx    <= c_negx_reg;
            d_side_reg.negy    <= c_negy_reg;
            d_side_reg.hi      <= hi;
            d_side_reg.clamped <= c_clamped_reg;
            d_side_reg.kill    <= (c_s_reg == '0) || (!c_clamped_reg && dead);
            d_side_reg.dzr     <= c_dzr_reg;
            d_side_reg.den     <= c_den_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign radicand  = d_v_reg;
    assign side      = d_side_reg;

endmodule

// ===== src/vsrdz_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on vsrdz_pkg and the assertion header.
`include "virtual_stick_radial_dead_zone_assert.svh"
module vsrdz_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [vsrdz_pkg::RAD_W-1:0]   radicand,
    input  vsrdz_pkg::side_t              in_side,
    output logic                          out_valid,
    output logic [vsrdz_pkg::ROOT_W-1:0]  root,
    output vsrdz_pkg::side_t              out_side
);
    import vsrdz_pkg::*;

    logic               valid_reg [ROOT_W];
    logic [SQREM_W-1:0] rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]  root_reg  [ROOT_W];
    logic [RAD_W-1:0]   rest_reg  [ROOT_W];
    side_t              side_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic               valid_in;
        logic [SQREM_W-1:0] rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [RAD_W-1:0]   rest_in;
        side_t              side_in;
        sq_step_t           step;

        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rest_in  = radicand;
            assign side_in  = in_side;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign root_in  = root_reg[i-1];
            assign rest_in  = rest_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        assign step = sqrt_step(rem_in, root_in, rest_in[RAD_W-1:RAD_W-2]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i]  <= step.rem;
                root_reg[i] <= step.root;
                rest_reg[i] <= {rest_in[RAD_W-3:0], 2'b00};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

    // The final remainder of a floor square root never exceeds twice the root.
    `VSRDZ_CHECK(a_sqrt_rem_bound,
        !valid_reg[ROOT_W-1] || (rem_reg[ROOT_W-1] <= {1'b0, root_reg[ROOT_W-1], 1'b0}))

endmodule

// ===== src/vsrdz_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on vsrdz_pkg and the assertion header.
`include "virtual_stick_radial_dead_zone_assert.svh"
module vsrdz_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [vsrdz_pkg::NUM_W-1:0]   num [vsrdz_pkg::DIV_LANES],
    input  logic [vsrdz_pkg::DEN_W-1:0]   den [vsrdz_pkg::DIV_LANES],
    input  vsrdz_pkg::tail_t              in_tail,
    output logic                          out_valid,
    output logic [vsrdz_pkg::Q_W-1:0]     quot [vsrdz_pkg::DIV_LANES],
    output vsrdz_pkg::tail_t              out_tail
);
    import vsrdz_pkg::*;

    logic              valid_reg [Q_W];
    tail_t             tail_reg  [Q_W];
    logic [QREM_W-1:0] rem_reg   [Q_W][DIV_LANES];
    logic [Q_W-1:0]    low_reg   [Q_W][DIV_LANES];
    logic [Q_W-1:0]    q_reg     [Q_W][DIV_LANES];
    logic [DEN_W-1:0]  d_reg     [Q_W][DIV_LANES];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic valid_in;
        tail_t tail_in;

        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign tail_in  = in_tail;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[i-1];
            assign tail_in  = tail_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tail_reg[i] <= tail_in;
            end
        end

        for (genvar k = 0; k < DIV_LANES; k++)
        begin : g_lane
            logic [QREM_W-1:0] rem_in;
            logic [Q_W-1:0]    low_in;
            logic [Q_W-1:0]    q_in;
            logic [DEN_W-1:0]  d_in;
            dv_step_t          step;

            // The quotient is known to fit in Q_W bits, so the upper numerator
            // bits start out below the divisor.
            if (i == 0)
            begin : g_first
                assign rem_in = {{(QREM_W-NUM_W+Q_W){1'b0}}, num[k][NUM_W-1:Q_W]};
                assign low_in = num[k][Q_W-1:0];
                assign q_in   = '0;
                assign d_in   = den[k];
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1][k];
                assign low_in = low_reg[i-1][k];
                assign q_in   = q_reg[i-1][k];
                assign d_in   = d_reg[i-1][k];
            end

            assign step = div_step(rem_in, low_in[Q_W-1], d_in);

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[i][k] <= step.rem;
                    low_reg[i][k] <= {low_in[Q_W-2:0], 1'b0};
                    q_reg[i][k]   <= {q_in[Q_W-2:0], step.qbit};
                    d_reg[i][k]   <= d_in;
                end
            end
        end

        if (i == Q_W - 1)
        begin : g_out
            for (genvar k = 0; k < DIV_LANES; k++)
            begin : g_q
                assign quot[k] = q_reg[i][k];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_tail  = tail_reg[Q_W-1];

    // A live item leaves the x direction divider with a remainder below the divisor.
    `VSRDZ_CHECK(a_div_rem_x,
        !valid_reg[Q_W-1] || tail_reg[Q_W-1].kill ||
        (rem_reg[Q_W-1][LANE_X] < {1'b0, d_reg[Q_W-1][LANE_X]}))
    // The ramp quotient is only used, and only bounded, below the unit circle.
    `VSRDZ_CHECK(a_div_rem_g,
        !valid_reg[Q_W-1] || tail_reg[Q_W-1].kill || tail_reg[Q_W-1].clamped ||
        (rem_reg[Q_W-1][LANE_G] < {1'b0, d_reg[Q_W-1][LANE_G]}))

endmodule

// ===== src/virtual_stick_radial_dead_zone.sv =====
// Virtual thumb-stick with a radial dead zone: top level and output stages.
// Depends on vsrdz_pkg, vsrdz_front, vsrdz_sqrt, vsrdz_div and the assertion header.
//
// Input channel s_axis carries one touch sample per request: touch and origin
// positions plus the stick radius. Output channel m_axis returns one Q1.15
// axis pair per request, in order. The dead zone is written through the cfg
// channel, which is always ready; write it only while no request is in flight.
//
// From input to output a request passes four front stages, 32 square
// root stages (one root bit each), one divider setup stage, 22 divider stages
// (one quotient bit each), one multiply stage and the output register.
// Throughput is one request per cycle while the receiver does not stall.
//
// Reset clears every valid bit and loads the dead zone with about 0.15.
// When the receiver stalls the whole pipeline holds in place and s_axis_tready
// drops; nothing is lost or repeated, and ready returns as soon as the held
// output is taken.
`include "virtual_stick_radial_dead_zone_assert.svh"
module virtual_stick_radial_dead_zone (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // touch_x[17:0], touch_y[35:18], origin_x[53:36], origin_y[71:54],
    // stick_radius[87:72]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // axis_x[15:0], axis_y[31:16]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import vsrdz_pkg::*;

    logic               advance;
    logic [DZ_W-1:0]    dz_reg;

    logic               f_valid;
    logic [RAD_W-1:0]   f_radicand;
    side_t              f_side;

    logic               q_valid;
    logic [ROOT_W-1:0]  q_root;
    side_t              q_side;

    logic               e_valid_reg;
    logic [NUM_W-1:0]   e_num_reg [DIV_LANES];
    logic [DEN_W-1:0]   e_den_reg [DIV_LANES];
    tail_t              e_tail_reg;
    logic [ROOT_W-1:0]  ramp_num;
    logic [NUM_W-1:0]   dir_x_num, dir_y_num;

    logic               v_valid;
    logic [Q_W-1:0]     v_quot [DIV_LANES];
    tail_t              v_tail;
    logic [U_W-1:0]     ux, uy, gain;

    logic               p_valid_reg;
    logic [2*U_W-1:0]   p_x_reg, p_y_reg;
    tail_t              p_tail_reg;
    logic [16:0]        mag_x, mag_y;
    logic [AXIS_W-1:0]  axis_x, axis_y;

    logic               o_valid_reg;
    logic [AXIS_W-1:0]  o_x_reg, o_y_reg;

    assign advance       = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= DZ_RESET;
        end
        else if (cfg_valid)
        begin
            dz_reg <= cfg_data;
        end
    end

    vsrdz_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (s_axis_tvalid),
        .touch_x      (s_axis_tdata[17:0]),
        .touch_y      (s_axis_tdata[35:18]),
        .origin_x     (s_axis_tdata[53:36]),
        .origin_y     (s_axis_tdata[71:54]),
        .stick_radius (s_axis_tdata[87:72]),
        .dead_zone    (dz_reg),
        .out_valid    (f_valid),
        .radicand     (f_radicand),
        .side         (f_side)
    );

    vsrdz_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (f_valid),
        .radicand  (f_radicand),
        .in_side   (f_side),
        .out_valid (q_valid),
        .root      (q_root),
        .out_side  (q_side)
    );

    // Direction numerators are |d| scaled by 2^(20+h), with h = 16 or 12.
    assign dir_x_num = q_side.hi ? {4'b0, q_side.adx, 32'b0} : {q_side.adx, 36'b0};
    assign dir_y_num = q_side.hi ? {4'b0, q_side.ady, 32'b0} : {q_side.ady, 36'b0};
    assign ramp_num  = (q_root > q_side.dzr) ? (q_root - q_side.dzr) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e_valid_reg <= q_valid;
            p_valid_reg <= v_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_num_reg[LANE_X]  <= dir_x_num;
            e_num_reg[LANE_Y]  <= dir_y_num;
            e_num_reg[LANE_G]  <= {2'b0, ramp_num, 20'b0};
            e_den_reg[LANE_X]  <= {1'b0, q_root};
            e_den_reg[LANE_Y]  <= {1'b0, q_root};
            e_den_reg[LANE_G]  <= q_side.den;
            e_tail_reg.negx    <= q_side.negx;
            e_tail_reg.negy    <= q_side.negy;
            e_tail_reg.clamped <= q_side.clamped;
            e_tail_reg.kill    <= q_side.kill;
        end
    end

    vsrdz_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (e_valid_reg),
        .num       (e_num_reg),
        .den       (e_den_reg),
        .in_tail   (e_tail_reg),
        .out_valid (v_valid),
        .quot      (v_quot),
        .out_tail  (v_tail)
    );

    assign ux   = (v_quot[LANE_X] > {1'b0, ONE_Q20}) ? ONE_Q20 : v_quot[LANE_X][U_W-1:0];
    assign uy   = (v_quot[LANE_Y] > {1'b0, ONE_Q20}) ? ONE_Q20 : v_quot[LANE_Y][U_W-1:0];
    assign gain = (v_tail.clamped || (v_quot[LANE_G] > {1'b0, ONE_Q20})) ?
                  ONE_Q20 : v_quot[LANE_G][U_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_x_reg    <= ux * gain;
            p_y_reg    <= uy * gain;
            p_tail_reg <= v_tail;
        end
    end

    assign mag_x = p_x_reg[2*U_W-1:25];
    assign mag_y = p_y_reg[2*U_W-1:25];

    // A positive full deflection saturates; the negative one fits exactly.
    always_comb
    begin
        if (p_tail_reg.kill)
        begin
            axis_x = '0;
            axis_y = '0;
        end
        else
        begin
            if (p_tail_reg.negx)
                axis_x = 16'd0 - mag_x[15:0];
            else
                axis_x = mag_x[16] || mag_x[15] ? 16'h7FFF : mag_x[15:0];
            if (p_tail_reg.negy)
                axis_y = 16'd0 - mag_y[15:0];
            else
                axis_y = mag_y[16] || mag_y[15] ? 16'h7FFF : mag_y[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_x_reg <= axis_x;
            o_y_reg <= axis_y;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {o_y_reg, o_x_reg};

    // Whenever the pipeline moves, the output takes the valid bit of the stage before it.
    `VSRDZ_CHECK_NEXT(a_out_follows_mult, advance, o_valid_reg == $past(p_valid_reg))

endmodule
